FILE: sv/plmi_pkg.sv
// Shared types and constants for the palindrome minimum-insertion block.
// Used by plmi_cell, plmi_chain and palindrome_min_insertions_lcs_core.
// No dependencies.
package plmi_pkg;

   localparam int MAX_LEN_DEF = 256;
   localparam int SYM_W       = 8;
   localparam int LPS_W       = 9;
   localparam int INS_W       = 8;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             end_of_string;
   } req_type;

   typedef struct packed {
      logic [LPS_W-1:0] lps_length;
      logic [INS_W-1:0] insertions;
      logic             overflow;
   } rsp_type;

   // One row of the LCS table travelling down the cell chain.
   typedef struct packed {
      logic             vld;
      logic             last;
      logic [SYM_W-1:0] sym;
   } row_ctl_type;

   // Column-side controls broadcast to every cell.
   typedef struct packed {
      logic shift;
      logic clr_val;
      logic clr_loaded;
   } col_ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN
   } state_type;

endpackage

FILE: sv/palindrome_min_insertions_lcs_core.sv
// Longest palindromic subsequence / minimum insertions via an LCS cell chain.
// Load: one byte beat per cycle while in the load state; an end beat also waits
// while the previous response is held. After the end beat, n rows (n = stored bytes)
// are read back from the symbol RAM, then the wavefront crosses all MAX_LEN cells and
// the response beat follows. Next string may load once that is done.
// Reset clears control, counts and cell values; the symbol RAM is not cleared. Depends on plmi_pkg and plmi_chain.
module palindrome_min_insertions_lcs_core
   import plmi_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              res_ovf_ff, res_ovf_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rd_vld_ff;
   logic              rd_last_ff;
   logic [SYM_W-1:0]  rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic [SYM_W-1:0]  sym_mem [0:MAX_LEN-1];

   logic              req_acc;
   logic              store;
   logic              rd_issue;
   logic              fin;
   logic [CNT_W-1:0]  count_next;
   col_ctl_type       col_ctl;
   row_ctl_type       row_feed;
   row_ctl_type       row_end;
   logic [CNT_W-1:0]  lps_val;

   // an end beat waits while the previous response is still held
   assign req_stall  = (state_ff != ST_LOAD) || (rsp_valid_ff && req_data.end_of_string);
   assign req_acc    = req_valid && !req_stall;
   assign store      = req_acc && (count_ff < CNT_W'(MAX_LEN));
   assign count_next = store ? (count_ff + CNT_W'(1)) : count_ff;
   assign fin        = row_end.vld && row_end.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      rd_issue    = 1'b0;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      n_in        = n_ff;
      res_ovf_in  = res_ovf_ff;
      rd_addr_in  = rd_addr_ff;
      col_ctl     = '0;
      col_ctl.shift = store;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               count_in = count_next;
               ovf_in   = ovf_ff || !store;
               if (req_data.end_of_string) begin
                  n_in            = count_next;
                  res_ovf_in      = ovf_ff || !store;
                  rd_addr_in      = ADDR_W'(count_next - CNT_W'(1));
                  count_in        = '0;
                  ovf_in          = 1'b0;
                  col_ctl.clr_val = 1'b1;
                  state_in        = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // rows go in reversed order; columns hold the string forward
            rd_issue   = 1'b1;
            rd_addr_in = rd_addr_ff - ADDR_W'(1);
            if (rd_addr_ff == '0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (fin) begin
               col_ctl.clr_loaded = 1'b1;
               state_in           = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         rd_vld_ff <= rd_issue;
         rd_last_ff <= rd_issue && (rd_addr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      res_ovf_ff <= res_ovf_in;
      rd_addr_ff <= rd_addr_in;
   end

   always_ff @(posedge clock) begin
      if (store) begin
         sym_mem[count_ff[ADDR_W-1:0]] <= req_data.symbol;
      end
      if (rd_issue) begin
         rd_data_ff <= sym_mem[rd_addr_ff];
      end
   end

   assign row_feed.vld  = rd_vld_ff;
   assign row_feed.last = rd_last_ff;
   assign row_feed.sym  = rd_data_ff;

   plmi_chain #(
      .MAX_LEN (MAX_LEN),
      .VAL_W   (CNT_W)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .col_ctl    (col_ctl),
      .col_sym_in (req_data.symbol),
      .row_in     (row_feed),
      .row_out    (row_end),
      .val_out    (lps_val)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_ff.lps_length <= LPS_W'(lps_val);
         rsp_ff.insertions <= INS_W'(n_ff - lps_val);
         rsp_ff.overflow   <= res_ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fin_in_drain: assert property (@(posedge clock) disable iff (reset)
      fin |-> state_ff == ST_DRAIN)
      else $error("wavefront finished outside drain");

   a_acc_in_load: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> state_ff == ST_LOAD)
      else $error("byte accepted while computing");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LEN))
      else $error("symbol count beyond capacity");

   a_fin_no_pending: assert property (@(posedge clock) disable iff (reset)
      fin |-> !rsp_valid_ff || !rsp_stall)
      else $error("result would overwrite a held response");

   a_fin_rsp: assert property (@(posedge clock) disable iff (reset)
      fin |=> rsp_valid_ff && $stable(n_ff))
      else $error("response not raised after finish");

endmodule

FILE: sv/plmi_cell.sv
// One column cell of the LCS wavefront: holds a column symbol and its table value.
// Depends on plmi_pkg.
module plmi_cell
   import plmi_pkg::*;
#(
   parameter int VAL_W = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  col_ctl_type       col_ctl,
   input  logic [SYM_W-1:0]  col_sym_in,
   input  logic              col_loaded_in,
   output logic [SYM_W-1:0]  col_sym_out,
   output logic              col_loaded_out,
   input  row_ctl_type       row_in,
   input  logic [VAL_W-1:0]  left_in,
   input  logic [VAL_W-1:0]  diag_in,
   output row_ctl_type       row_out,
   output logic [VAL_W-1:0]  left_out,
   output logic [VAL_W-1:0]  diag_out
);

   logic [SYM_W-1:0] col_sym_ff;
   logic             loaded_ff;
   logic [VAL_W-1:0] val_ff;
   logic [VAL_W-1:0] val_in;
   row_ctl_type      row_ff;
   logic [VAL_W-1:0] new_ff;
   logic [VAL_W-1:0] old_ff;

   // Unloaded cells sit left of the string and act as a zero column.
   always_comb begin
      if (!loaded_ff) begin
         val_in = '0;
      end else if (row_in.sym == col_sym_ff) begin
         val_in = diag_in + VAL_W'(1);
      end else if (val_ff > left_in) begin
         val_in = val_ff;
      end else begin
         val_in = left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (col_ctl.shift) begin
         col_sym_ff <= col_sym_in;
      end
      if (row_in.vld) begin
         new_ff <= val_in;
         old_ff <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || col_ctl.clr_loaded) begin
         loaded_ff <= 1'b0;
      end else if (col_ctl.shift) begin
         loaded_ff <= col_loaded_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || col_ctl.clr_val) begin
         val_ff <= '0;
      end else if (row_in.vld) begin
         val_ff <= val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign col_sym_out    = col_sym_ff;
   assign col_loaded_out = loaded_ff;
   assign row_out        = row_ff;
   assign left_out       = new_ff;
   assign diag_out       = old_ff;

endmodule

FILE: sv/plmi_chain.sv
// Row of MAX_LEN column cells; rows enter at cell 0, new symbols at the far end.
// Depends on plmi_pkg and plmi_cell.
module plmi_chain
   import plmi_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF,
   parameter int VAL_W   = $clog2(MAX_LEN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  col_ctl_type       col_ctl,
   input  logic [SYM_W-1:0]  col_sym_in,
   input  row_ctl_type       row_in,
   output row_ctl_type       row_out,
   output logic [VAL_W-1:0]  val_out
);

   logic [SYM_W-1:0] sym_link    [0:MAX_LEN];
   logic             loaded_link [0:MAX_LEN];
   row_ctl_type      row_link    [0:MAX_LEN];
   logic [VAL_W-1:0] left_link   [0:MAX_LEN];
   logic [VAL_W-1:0] diag_link   [0:MAX_LEN];

   assign sym_link[MAX_LEN]    = col_sym_in;
   assign loaded_link[MAX_LEN] = 1'b1;
   assign row_link[0]          = row_in;
   assign left_link[0]         = '0;
   assign diag_link[0]         = '0;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      plmi_cell #(
         .VAL_W (VAL_W)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .col_ctl        (col_ctl),
         .col_sym_in     (sym_link[k+1]),
         .col_loaded_in  (loaded_link[k+1]),
         .col_sym_out    (sym_link[k]),
         .col_loaded_out (loaded_link[k]),
         .row_in         (row_link[k]),
         .left_in        (left_link[k]),
         .diag_in        (diag_link[k]),
         .row_out        (row_link[k+1]),
         .left_out       (left_link[k+1]),
         .diag_out       (diag_link[k+1])
      );
   end

   assign row_out = row_link[MAX_LEN];
   assign val_out = left_link[MAX_LEN];

endmodule
